// ===== src/nearest_neighbor_image_scaler_macros.svh =====
// Assertion helpers shared by the RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_MACROS_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_MACROS_SVH

// Same-cycle implication.
`define NNS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/nns_pkg.sv =====
package nns_pkg;

    localparam int DIM_W      = 12;
    localparam int COORD_W    = 11;
    localparam int POS_W      = 22;
    localparam int PIX_W      = 24;
    localparam int PROD_W     = COORD_W + DIM_W;
    localparam int AREA_W     = 2 * DIM_W;
    localparam int IDX_W      = 2 * DIM_W + 1;

    // Divider: dividend padded to an even width, two quotient bits per cycle.
    localparam int DIV_BITS   = 2;
    localparam int DIV_W      = ((PROD_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int DIV_STEPS  = DIV_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    typedef logic [DIM_W-1:0] t_dim;

    typedef enum logic [1:0] {
        CFG_SRC_W,
        CFG_SRC_H,
        CFG_DST_W,
        CFG_DST_H
    } t_cfg_index;

    typedef enum logic {
        OP_LOAD,
        OP_FETCH
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CLAMP,
        ST_INDEX,
        ST_READ,
        ST_OUT
    } t_state;

    // Zero acts as one, anything above the limit acts as the limit.
    function automatic t_dim eff_dim(input t_dim v, input logic [DIM_W:0] max_dim);
        t_dim r;
        if (v == '0) begin
            r = t_dim'(1);
        end else if ({1'b0, v} > max_dim) begin
            r = max_dim[DIM_W-1:0];
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== src/nns_store.sv =====
module nns_store #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [nns_pkg::PIX_W-1:0]  i_wdata,
    input  logic                       i_re,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic [nns_pkg::PIX_W-1:0]  o_rdata
);

    logic [nns_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [nns_pkg::PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/nns_div.sv =====
module nns_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nns_pkg::DIV_W-1:0]   i_dividend,
    input  nns_pkg::t_dim               i_divisor,
    output logic                        o_busy,
    output logic [nns_pkg::DIV_W-1:0]   o_quotient
);

    logic [nns_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [nns_pkg::DIV_W-1:0]     r_quo;
    logic [nns_pkg::DIV_W-1:0]     n_quo;
    nns_pkg::t_dim                 r_rem;
    nns_pkg::t_dim                 n_rem;
    nns_pkg::t_dim                 r_div;
    logic [nns_pkg::DIM_W:0]       shifted;

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

    // Restoring division: dividend bits shift out the top, quotient bits in at the bottom.
    always_comb begin
        n_quo   = r_quo;
        n_rem   = r_rem;
        shifted = '0;
        for (int i = 0; i < nns_pkg::DIV_BITS; i++) begin
            shifted = {n_rem, n_quo[nns_pkg::DIV_W-1]};
            n_quo   = {n_quo[nns_pkg::DIV_W-2:0], 1'b0};
            if (shifted >= {1'b0, r_div}) begin
                n_rem    = nns_pkg::DIM_W'(shifted - {1'b0, r_div});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = shifted[nns_pkg::DIM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= nns_pkg::DIV_CNT_W'(nns_pkg::DIV_STEPS);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (o_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

endmodule

// ===== src/nearest_neighbor_image_scaler.sv =====
// Nearest-neighbor image scaler with an on-chip frame store for 24-bit BGR pixels.
// Input stream (s_axis): tuser selects the operation, 0 = load, 1 = fetch.
//   A load writes tdata into the store at the next source raster position.
//   A fetch returns the next destination pixel, read from source column
//   floor(x*src_w/dst_w) and row floor(y*src_h/dst_h).
// Output stream (m_axis): exactly one transaction per input transaction, in order.
//   tdata is the pixel (zero for loads), tlast marks the end of the source load
//   or of the destination frame, tuser flags a load dropped for lack of store space.
// Configuration: write i_cfg_data to register i_cfg_index while the block is idle.
// One item is in work at a time: the next item is taken only after the result of the
// last one has entered the output register. A load passes the load state on its way
// to the output register. A fetch passes the scale multiply, the two coordinate
// dividers that resolve two quotient bits per cycle, the clamp, the index multiply
// and the registered store read before it reaches the output register.
// A finished result waits in the output register; the next item is accepted
// meanwhile, but its result is held back while the receiver stalls.
// Reset clears the counters, sets all sizes to 1 and empties the output register;
// the store contents are undefined until loaded.
`include "nearest_neighbor_image_scaler_macros.svh"

module nearest_neighbor_image_scaler #(
    parameter int STORE_PIXELS  = 65536,
    parameter int MAX_DIMENSION = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // in_blue[7:0], in_green[15:8], in_red[23:16]
    input  logic        s_axis_tuser,   // op[0]
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_blue[7:0], out_green[15:8], out_red[23:16]
    output logic        m_axis_tlast,   // frame_end
    output logic        m_axis_tuser    // status[0]
);

    localparam int ADDR_W = (STORE_PIXELS > 1) ? $clog2(STORE_PIXELS) : 1;

    nns_pkg::t_state r_state;
    nns_pkg::t_state n_state;

    nns_pkg::t_dim r_src_w, r_src_h, r_dst_w, r_dst_h;
    nns_pkg::t_dim sw, sh, tw, th;
    logic [nns_pkg::AREA_W-1:0] r_area;

    logic [nns_pkg::POS_W-1:0]   r_load_pos;
    logic [nns_pkg::COORD_W-1:0] r_col, r_row;

    // item in work
    nns_pkg::t_op                r_op;
    logic [nns_pkg::PIX_W-1:0]   r_pix;
    logic [nns_pkg::COORD_W-1:0] r_x, r_y;
    logic                        r_fend;
    logic                        r_status;
    logic [nns_pkg::PROD_W-1:0]  r_px, r_py;
    nns_pkg::t_dim               r_sx, r_sy;
    logic [nns_pkg::IDX_W-1:0]   r_idx;
    logic                        r_hit;

    logic [nns_pkg::DIV_W-1:0]   q_x, q_y;
    logic                        busy_x, busy_y;
    logic                        div_start;

    logic                        mem_we, mem_re;
    logic [nns_pkg::PIX_W-1:0]   rdata;

    logic                        in_accept;
    logic                        out_load;
    logic                        load_fits, load_wrap;
    logic [nns_pkg::POS_W:0]     load_next;
    logic [nns_pkg::DIM_W-1:0]   x_next, y_next;
    logic                        col_wrap, row_wrap;

    logic                        r_m_tvalid;
    logic [nns_pkg::PIX_W-1:0]   r_m_tdata;
    logic                        r_m_tlast;
    logic                        r_m_tuser;

    assign sw = nns_pkg::eff_dim(r_src_w, (nns_pkg::DIM_W + 1)'(MAX_DIMENSION));
    assign sh = nns_pkg::eff_dim(r_src_h, (nns_pkg::DIM_W + 1)'(MAX_DIMENSION));
    assign tw = nns_pkg::eff_dim(r_dst_w, (nns_pkg::DIM_W + 1)'(MAX_DIMENSION));
    assign th = nns_pkg::eff_dim(r_dst_h, (nns_pkg::DIM_W + 1)'(MAX_DIMENSION));

    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign load_next = {1'b0, r_load_pos} + 1'b1;
    assign load_fits = {1'b0, r_load_pos} < (nns_pkg::POS_W + 1)'(STORE_PIXELS);
    assign load_wrap = nns_pkg::AREA_W'(load_next) >= r_area;

    assign x_next   = {1'b0, r_col} + 1'b1;
    assign y_next   = {1'b0, r_row} + 1'b1;
    assign col_wrap = x_next >= tw;
    assign row_wrap = y_next >= th;

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nns_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = (nns_pkg::t_op'(s_axis_tuser) == nns_pkg::OP_FETCH) ?
                              nns_pkg::ST_MUL : nns_pkg::ST_LOAD;
                end
            end
            nns_pkg::ST_LOAD:      n_state = nns_pkg::ST_OUT;
            nns_pkg::ST_MUL:       n_state = nns_pkg::ST_DIV_START;
            nns_pkg::ST_DIV_START: n_state = nns_pkg::ST_DIV_WAIT;
            nns_pkg::ST_DIV_WAIT: begin
                if (!busy_x && !busy_y) begin
                    n_state = nns_pkg::ST_CLAMP;
                end
            end
            nns_pkg::ST_CLAMP:     n_state = nns_pkg::ST_INDEX;
            nns_pkg::ST_INDEX:     n_state = nns_pkg::ST_READ;
            nns_pkg::ST_READ:      n_state = nns_pkg::ST_OUT;
            nns_pkg::ST_OUT: begin
                if (out_load) begin
                    n_state = nns_pkg::ST_IDLE;
                end
            end
            default:               n_state = nns_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            nns_pkg::ST_IDLE:      s_axis_tready = 1'b1;
            nns_pkg::ST_LOAD:      mem_we        = load_fits;
            nns_pkg::ST_DIV_START: div_start     = 1'b1;
            nns_pkg::ST_READ:      mem_re        = 1'b1;
            nns_pkg::ST_OUT:       out_load      = !r_m_tvalid || m_axis_tready;
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= nns_pkg::ST_IDLE;
            r_src_w    <= nns_pkg::t_dim'(1);
            r_src_h    <= nns_pkg::t_dim'(1);
            r_dst_w    <= nns_pkg::t_dim'(1);
            r_dst_h    <= nns_pkg::t_dim'(1);
            r_load_pos <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (nns_pkg::t_cfg_index'(i_cfg_index))
                    nns_pkg::CFG_SRC_W: r_src_w <= i_cfg_data;
                    nns_pkg::CFG_SRC_H: r_src_h <= i_cfg_data;
                    nns_pkg::CFG_DST_W: r_dst_w <= i_cfg_data;
                    nns_pkg::CFG_DST_H: r_dst_h <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // advance the destination raster at fetch accept
            if (in_accept && nns_pkg::t_op'(s_axis_tuser) == nns_pkg::OP_FETCH) begin
                if (col_wrap) begin
                    r_col <= '0;
                    r_row <= row_wrap ? '0 : y_next[nns_pkg::COORD_W-1:0];
                end else begin
                    r_col <= x_next[nns_pkg::COORD_W-1:0];
                end
            end

            // the position advances even when the store is full
            if (r_state == nns_pkg::ST_LOAD) begin
                r_load_pos <= load_wrap ? '0 : load_next[nns_pkg::POS_W-1:0];
            end

            if (out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        r_area <= nns_pkg::AREA_W'(sw) * nns_pkg::AREA_W'(sh);
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            nns_pkg::ST_IDLE: begin
                if (in_accept) begin
                    r_op     <= nns_pkg::t_op'(s_axis_tuser);
                    r_pix    <= s_axis_tdata;
                    r_x      <= r_col;
                    r_y      <= r_row;
                    r_status <= 1'b0;
                    r_fend   <= (nns_pkg::t_op'(s_axis_tuser) == nns_pkg::OP_FETCH) &&
                                col_wrap && row_wrap;
                end
            end
            nns_pkg::ST_LOAD: begin
                r_status <= !load_fits;
                r_fend   <= load_wrap;
            end
            nns_pkg::ST_MUL: begin
                r_px <= nns_pkg::PROD_W'(r_x) * nns_pkg::PROD_W'(sw);
                r_py <= nns_pkg::PROD_W'(r_y) * nns_pkg::PROD_W'(sh);
            end
            nns_pkg::ST_CLAMP: begin
                // hold coordinates inside the source after a size change
                r_sx <= (q_x > nns_pkg::DIV_W'(sw - 1'b1)) ? sw - 1'b1
                                                           : q_x[nns_pkg::DIM_W-1:0];
                r_sy <= (q_y > nns_pkg::DIV_W'(sh - 1'b1)) ? sh - 1'b1
                                                           : q_y[nns_pkg::DIM_W-1:0];
            end
            nns_pkg::ST_INDEX: begin
                r_idx <= nns_pkg::IDX_W'(r_sy) * nns_pkg::IDX_W'(sw) + nns_pkg::IDX_W'(r_sx);
            end
            nns_pkg::ST_READ: begin
                r_hit <= r_idx < nns_pkg::IDX_W'(STORE_PIXELS);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_tdata <= (r_op == nns_pkg::OP_FETCH && r_hit) ? rdata : '0;
            r_m_tlast <= r_fend;
            r_m_tuser <= r_status;
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tlast  = r_m_tlast;
    assign m_axis_tuser  = r_m_tuser;

    // ---------------------------------------------------------------- units
    nns_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({{(nns_pkg::DIV_W - nns_pkg::PROD_W){1'b0}}, r_px}),
        .i_divisor  (tw),
        .o_busy     (busy_x),
        .o_quotient (q_x)
    );

    nns_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({{(nns_pkg::DIV_W - nns_pkg::PROD_W){1'b0}}, r_py}),
        .i_divisor  (th),
        .o_busy     (busy_y),
        .o_quotient (q_y)
    );

    nns_store #(
        .DEPTH  (STORE_PIXELS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_load_pos[ADDR_W-1:0]),
        .i_wdata (r_pix),
        .i_re    (mem_re),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    // ---------------------------------------------------------------- assertions
    `NNS_ASSERT_NEXT(a_one_item, in_accept, !s_axis_tready, "second item taken while busy")
    `NNS_ASSERT_NOW(a_div_done, r_state == nns_pkg::ST_CLAMP, !busy_x && !busy_y, "divider still running at clamp")
    `NNS_ASSERT_NOW(a_src_inside, r_state == nns_pkg::ST_INDEX, r_sx < sw && r_sy < sh, "source coordinate outside frame")
    `NNS_ASSERT_NEXT(a_result_shown, out_load, r_m_tvalid && r_state == nns_pkg::ST_IDLE, "result not presented")

endmodule
